// ===== hdl/assert_macros.svh =====
// assertion macros shared by the receiver rtl
// each macro expects clk and arst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ccfr_pkg.sv =====
// shared types, codes and the byte-wide crc-32 function of the chunk receiver
// no dependencies
`timescale 1ns / 1ps

package ccfr_pkg;

	// default chunk payload limit
	localparam int CHUNK_MAX_DEF = 4096;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// crc-32, reflected ieee form
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// operation codes of an input request
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD = 3'd1;
	localparam logic [2:0] KIND_COMMIT  = 3'd2;
	localparam logic [2:0] KIND_START   = 3'd3;
	localparam logic [2:0] KIND_FINISH  = 3'd4;

	// final status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_EARLY   = 3'd2;
	localparam logic [2:0] ST_BADLEN  = 3'd3;
	localparam logic [2:0] ST_CRCBAD  = 3'd4;
	localparam logic [2:0] ST_FILECRC = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_CRC   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_CHECK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// classified command from the front part
	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_START,
		CMD_BYTE,
		CMD_TICK
	} cmd_t;

	// receiver phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [31:0] bytes_received;
		logic [31:0] file_crc;
		logic        chunk_error_count;
	} result_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] expected_size;
		logic [31:0] expected_file_crc;
		logic        file_crc_check;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// one byte into a reflected crc-32
	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== hdl/ccfr_front.sv =====
// front part: accepts input requests and classifies them into commands
// depends on ccfr_pkg
`timescale 1ns / 1ps

module ccfr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  ccfr_pkg::item_t       item,
	output logic                  push_valid,
	input  logic                  push_ready,
	output ccfr_pkg::cmd_item_t   push_cmd
);
	import ccfr_pkg::*;

	logic      valid_s1;
	cmd_item_t cmd_s1;
	cmd_item_t cmd_d;
	logic      accept;

	// hold off the link while a classified request waits for the queue
	assign item_stall = valid_s1 && !push_ready;
	assign accept     = item_valid && !item_stall;

	// decode the operation code
	always_comb begin
		cmd_d.data = item.rx_byte;
		case (item.operation)
			OP_START: cmd_d.cmd = CMD_START;
			OP_BYTE:  cmd_d.cmd = CMD_BYTE;
			OP_TICK:  cmd_d.cmd = CMD_TICK;
			default:  cmd_d.cmd = CMD_NOP;
		endcase
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || push_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

// ===== hdl/ccfr_queue.sv =====
// short command queue between the front and back parts
// depends on ccfr_pkg
`timescale 1ns / 1ps

module ccfr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  ccfr_pkg::cmd_item_t   push_cmd,
	output logic                  pop_valid,
	input  logic                  pop,
	output ccfr_pkg::cmd_item_t   pop_cmd
);
	import ccfr_pkg::*;

	cmd_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q < QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hdl/ccfr_back.sv =====
// back part: chunk deframing state machine, crc tracking and result register
// depends on ccfr_pkg
`timescale 1ns / 1ps

module ccfr_back #(
	parameter int CHUNK_MAX = ccfr_pkg::CHUNK_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ccfr_pkg::cfg_t        cfg,
	input  logic                  pop_valid,
	output logic                  pop,
	input  ccfr_pkg::cmd_item_t   pop_cmd,
	output logic                  result_valid,
	input  logic                  result_stall,
	output ccfr_pkg::result_t     result
);
	import ccfr_pkg::*;

	localparam int LEN_W = $clog2(CHUNK_MAX + 1);

	typedef struct packed {
		logic       fin;
		logic [2:0] status;
		logic       cerr;
		logic [2:0] kind;
		logic       start;
		logic       enter;
		logic       tick_inc;
		logic       data;
		logic       gather;
		logic       load;
		logic       commit;
	} ev_t;

	phase_t            phase_q, phase_d;
	logic [1:0]        idx_q, idx_d;
	logic [31:0]       shift_q, shift_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic [31:0]       pend_q, pend_d;
	logic [31:0]       ccrc_q, ccrc_d;
	logic [31:0]       ftent_q, ftent_d;
	logic [31:0]       fcom_q, fcom_d;
	logic [31:0]       count_q, count_d;
	logic [15:0]       timer_q, timer_d;
	logic              out_valid_q;
	result_t           out_q;
	result_t           res_d;

	ev_t               ev;
	phase_t            nxt_phase;
	logic [31:0]       word;
	logic [32:0]       sum;
	logic              last_field;
	logic              over_len;
	logic [31:0]       fin_crc;

	// take a command whenever the result register is free or draining
	assign pop = pop_valid && (!out_valid_q || !result_stall);

	// field assembly and length checks
	assign word       = shift_q | (32'(pop_cmd.data) << {idx_q, 3'b000});
	assign last_field = idx_q == 2'd3;
	assign sum        = {1'b0, count_q} + {1'b0, word};
	assign over_len   = (word > 32'(CHUNK_MAX)) || (sum > {1'b0, cfg.expected_size});

	// event decode for the current command
	always_comb begin
		ev        = '0;
		ev.kind   = KIND_NONE;
		ev.status = ST_OK;
		nxt_phase = phase_q;
		if (pop) begin
			case (pop_cmd.cmd)
				CMD_START: begin
					ev.start = 1'b1;
					if (cfg.expected_size == '0) begin
						ev.fin = 1'b1;
					end else begin
						ev.enter  = 1'b1;
						nxt_phase = PH_HEADER;
						ev.kind   = KIND_START;
					end
				end
				CMD_TICK: begin
					if (phase_q != PH_IDLE) begin
						if (timer_q >= cfg.timeout_ticks) begin
							ev.fin    = 1'b1;
							ev.status = ST_TIMEOUT;
						end else begin
							ev.tick_inc = 1'b1;
						end
					end
				end
				CMD_BYTE: begin
					case (phase_q)
						PH_PAYLOAD: begin
							ev.data = 1'b1;
							ev.kind = KIND_PAYLOAD;
							if (left_q == LEN_W'(1)) begin
								ev.enter  = 1'b1;
								nxt_phase = PH_CRC;
							end
						end
						PH_HEADER: begin
							if (!last_field) begin
								ev.gather = 1'b1;
							end else if (word == '0) begin
								ev.fin    = 1'b1;
								ev.status = ST_EARLY;
							end else if (over_len) begin
								ev.fin    = 1'b1;
								ev.status = ST_BADLEN;
								ev.cerr   = 1'b1;
							end else begin
								ev.load   = 1'b1;
								ev.enter  = 1'b1;
								nxt_phase = PH_PAYLOAD;
							end
						end
						PH_CRC: begin
							if (!last_field) begin
								ev.gather = 1'b1;
							end else if (~ccrc_q != word) begin
								ev.fin    = 1'b1;
								ev.status = ST_CRCBAD;
								ev.cerr   = 1'b1;
							end else begin
								ev.commit = 1'b1;
								if (pend_q >= cfg.expected_size) begin
									ev.fin = 1'b1;
								end else begin
									ev.enter  = 1'b1;
									nxt_phase = PH_HEADER;
									ev.kind   = KIND_COMMIT;
								end
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
		// finish: back to idle, whole-file check on a clean end
		fin_crc = ev.commit ? ~ftent_q : (ev.start ? 32'h00000000 : ~fcom_q);
		if (ev.fin) begin
			ev.kind   = KIND_FINISH;
			ev.enter  = 1'b1;
			nxt_phase = PH_IDLE;
			if (ev.status == ST_OK && cfg.file_crc_check && fin_crc != cfg.expected_file_crc) begin
				ev.status = ST_FILECRC;
			end
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		shift_d = shift_q;
		left_d  = left_q;
		pend_d  = pend_q;
		ccrc_d  = ccrc_q;
		ftent_d = ftent_q;
		fcom_d  = fcom_q;
		count_d = count_q;
		timer_d = timer_q;
		if (ev.start) begin
			left_d  = '0;
			pend_d  = '0;
			ccrc_d  = CRC_INIT;
			ftent_d = CRC_INIT;
			fcom_d  = CRC_INIT;
			count_d = '0;
		end
		if (ev.tick_inc) begin
			timer_d = timer_q + 1'b1;
		end
		if (ev.data) begin
			ccrc_d  = crc32_byte(ccrc_q, pop_cmd.data);
			ftent_d = crc32_byte(ftent_q, pop_cmd.data);
			left_d  = left_q - 1'b1;
		end
		if (ev.gather) begin
			idx_d   = idx_q + 1'b1;
			shift_d = word;
		end
		if (ev.load) begin
			left_d  = word[LEN_W-1:0];
			pend_d  = sum[31:0];
			ccrc_d  = CRC_INIT;
			ftent_d = fcom_q;
		end
		if (ev.commit) begin
			count_d = pend_q;
			fcom_d  = ftent_q;
		end
		if (ev.enter) begin
			phase_d = nxt_phase;
			timer_d = '0;
			idx_d   = '0;
			shift_d = '0;
		end
	end

	// result fields
	always_comb begin
		res_d.kind              = ev.kind;
		res_d.payload_byte      = (ev.kind == KIND_PAYLOAD) ? pop_cmd.data : 8'h00;
		res_d.status            = ev.fin ? ev.status : ST_OK;
		res_d.bytes_received    = ev.commit ? pend_q : (ev.start ? 32'h00000000 : count_q);
		res_d.file_crc          = fin_crc;
		res_d.chunk_error_count = ev.fin && ev.cerr;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			idx_q       <= '0;
			shift_q     <= '0;
			left_q      <= '0;
			pend_q      <= '0;
			ccrc_q      <= CRC_INIT;
			ftent_q     <= CRC_INIT;
			fcom_q      <= CRC_INIT;
			count_q     <= '0;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			left_q  <= left_d;
			pend_q  <= pend_d;
			ccrc_q  <= ccrc_d;
			ftent_q <= ftent_d;
			fcom_q  <= fcom_d;
			count_q <= count_d;
			timer_q <= timer_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== hdl/chunk_crc_frame_receiver.sv =====
// top level of the length-prefixed chunk receiver with crc-32 checking
// depends on ccfr_pkg, ccfr_front, ccfr_queue, ccfr_back, assert_macros.svh
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   item     | item_valid/item_stall     | item (operation, rx_byte)
//   result   | result_valid/result_stall | result (kind .. chunk_error_count)
//   cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// one request accepted per cycle while item_stall is low, one result per request; from
// acceptance to result it passes the front stage, command queue and back result register
// the back state machine handles each request combinationally, byte-wide crc-32 included
// arst_n clears all control and crc state at once; no clearing pass
// a stalled result holds the back part; the two-entry queue then fills and
// stalls the front, which stalls the link
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chunk_crc_frame_receiver #(
	parameter int CHUNK_MAX = ccfr_pkg::CHUNK_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  ccfr_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output ccfr_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ccfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);
	import ccfr_pkg::*;

	cfg_t      cfg_q;
	logic      push_valid;
	logic      push_ready;
	cmd_item_t push_cmd;
	logic      pop_valid;
	logic      pop;
	cmd_item_t pop_cmd;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_size     <= '0;
			cfg_q.expected_file_crc <= '0;
			cfg_q.file_crc_check    <= 1'b0;
			cfg_q.timeout_ticks     <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EXP_SIZE:  cfg_q.expected_size     <= cfg_data;
				CFG_EXP_CRC:   cfg_q.expected_file_crc <= cfg_data;
				CFG_CRC_CHECK: cfg_q.file_crc_check    <= cfg_data[0];
				CFG_TIMEOUT:   cfg_q.timeout_ticks     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// request intake and classification
	ccfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	ccfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	// deframing and crc state machine
	ccfr_back #(
		.CHUNK_MAX (CHUNK_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_cmd      (pop_cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// accepted request shows up in the front stage next cycle
	`ASSERT_NEXT(a_accept_lands, item_valid && !item_stall, push_valid, "accepted request lost")
	// a command refused by the queue waits unchanged in the front stage
	`ASSERT_NEXT(a_front_holds, push_valid && !push_ready, push_valid && $stable(push_cmd), "front command dropped")
	// data byte only on payload results
	`ASSERT_ALWAYS(a_byte_kind, !result_valid || result.kind == KIND_PAYLOAD || result.payload_byte == 8'h00, "stray payload byte")
	// status and error flag only on finish results
	`ASSERT_ALWAYS(a_status_kind, !result_valid || result.kind == KIND_FINISH || (result.status == ST_OK && !result.chunk_error_count), "stray status")

endmodule

// ===== dv/tb_chunk_crc_frame_receiver.sv =====
// self-checking testbench for chunk_crc_frame_receiver: a directed opening, then random uploads
// built from well-formed chunked transfers mixed with broken ones, random idling on both sides
// depends on ccfr_pkg and the receiver rtl; expected results come from a predictor in this file
`timescale 1ns / 1ps

module tb_chunk_crc_frame_receiver;
	import ccfr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int LONG_HOLD = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	chunk_crc_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 10 ns clock
	always #5 clk = ~clk;

	// watchdog
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// receiver predictor: register copy and deframer state
	// ------------------------------------------------------------------
	logic [31:0] cfg_expected_size = '0;
	logic [31:0] cfg_expected_crc = '0;
	logic        cfg_crc_check = 1'b0;
	logic [15:0] cfg_timeout = TIMEOUT_RESET;

	phase_t      rx_phase = PH_IDLE;
	logic [1:0]  field_idx = '0;
	logic [31:0] field_acc = '0;
	logic [12:0] chunk_len = '0;
	logic [12:0] chunk_left = '0;
	logic [31:0] chunk_crc = CRC_INIT;
	logic [31:0] file_crc_pending = CRC_INIT;
	logic [31:0] file_crc_good = CRC_INIT;
	logic [31:0] good_count = '0;
	logic [15:0] phase_ticks = '0;

	// one byte into a reflected crc-32, data bit by data bit
	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] data);
		logic [31:0] c;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ ((c[0] ^ data[i]) ? CRC_POLY : 32'h0);
		end
		return c;
	endfunction

	function automatic result_t rx_report(input logic [2:0] kind, input logic [7:0] data,
			input logic [2:0] status, input logic cerr);
		result_t r;
		r.kind = kind;
		r.payload_byte = data;
		r.status = status;
		r.bytes_received = good_count;
		r.file_crc = ~file_crc_good;
		r.chunk_error_count = cerr;
		return r;
	endfunction

	function automatic void rx_enter(input phase_t p);
		rx_phase = p;
		phase_ticks = '0;
		field_idx = '0;
		field_acc = '0;
	endfunction

	// end of transfer, with the optional whole-file crc check on a clean end
	function automatic result_t rx_finish(input logic [2:0] status, input logic cerr);
		logic [2:0] st;
		st = status;
		if (st == ST_OK && cfg_crc_check && ~file_crc_good != cfg_expected_crc)
			st = ST_FILECRC;
		rx_enter(PH_IDLE);
		return rx_report(KIND_FINISH, 8'h00, st, cerr);
	endfunction

	function automatic result_t rx_predict(input item_t it);
		logic [31:0] len;
		if (it.operation == OP_START) begin
			chunk_len = '0;
			chunk_left = '0;
			chunk_crc = CRC_INIT;
			file_crc_pending = CRC_INIT;
			file_crc_good = CRC_INIT;
			good_count = '0;
			if (cfg_expected_size == 32'h0)
				return rx_finish(ST_OK, 1'b0);
			rx_enter(PH_HEADER);
			return rx_report(KIND_START, 8'h00, ST_OK, 1'b0);
		end
		if (it.operation == OP_TICK) begin
			if (rx_phase != PH_IDLE) begin
				if (phase_ticks >= cfg_timeout)
					return rx_finish(ST_TIMEOUT, 1'b0);
				phase_ticks++;
			end
			return rx_report(KIND_NONE, 8'h00, ST_OK, 1'b0);
		end
		if (it.operation != OP_BYTE || rx_phase == PH_IDLE)
			return rx_report(KIND_NONE, 8'h00, ST_OK, 1'b0);

		// payload bytes pass straight through
		if (rx_phase == PH_PAYLOAD) begin
			chunk_crc = crc_step(chunk_crc, it.rx_byte);
			file_crc_pending = crc_step(file_crc_pending, it.rx_byte);
			if (chunk_left != '0)
				chunk_left--;
			if (chunk_left == '0)
				rx_enter(PH_CRC);
			return rx_report(KIND_PAYLOAD, it.rx_byte, ST_OK, 1'b0);
		end

		// length or crc field, little endian
		field_acc |= 32'(it.rx_byte) << {field_idx, 3'b000};
		if (field_idx < 2'd3) begin
			field_idx++;
			return rx_report(KIND_NONE, 8'h00, ST_OK, 1'b0);
		end

		if (rx_phase == PH_HEADER) begin
			len = field_acc;
			if (len == 32'h0)
				return rx_finish(ST_EARLY, 1'b0);
			if (len > CHUNK_MAX_DEF ||
					{32'h0, good_count} + {32'h0, len} > {32'h0, cfg_expected_size})
				return rx_finish(ST_BADLEN, 1'b1);
			chunk_len = len[12:0];
			chunk_left = len[12:0];
			chunk_crc = CRC_INIT;
			file_crc_pending = file_crc_good;
			rx_enter(PH_PAYLOAD);
			return rx_report(KIND_NONE, 8'h00, ST_OK, 1'b0);
		end

		// crc field complete: commit or fail
		if (~chunk_crc != field_acc)
			return rx_finish(ST_CRCBAD, 1'b1);
		good_count += 32'(chunk_len);
		file_crc_good = file_crc_pending;
		if (good_count >= cfg_expected_size)
			return rx_finish(ST_OK, 1'b0);
		rx_enter(PH_HEADER);
		return rx_report(KIND_COMMIT, 8'h00, ST_OK, 1'b0);
	endfunction

	// ------------------------------------------------------------------
	// request driver and result monitor
	// ------------------------------------------------------------------
	item_t   pending[$];
	result_t expected_results[$];
	bit      send_idle_on = 1'b1;
	bit      recv_idle_on = 1'b1;
	int      gap_left = 0;
	bit      offering;
	int      stall_left = 0;
	int      hold_left = 0;
	int      results_seen = 0;
	int      fail_count = 0;

	// feed requests from the pending queue, with a random gap after each one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			gap_left = 0;
		end else begin
			offering = item_valid;
			if (item_valid && !item_stall) begin
				expected_results.push_back(rx_predict(item));
				offering = 1'b0;
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					item <= pending.pop_front();
					item_valid <= 1'b1;
					gap_left = send_idle_on ? $urandom_range(0, 5) : 0;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// check results in order; random stall after each, two long holds on the way
	result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: kind %0d", result.kind);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("kind", 32'(want.kind), 32'(result.kind));
					compare_field("payload_byte", 32'(want.payload_byte),
						32'(result.payload_byte));
					compare_field("status", 32'(want.status), 32'(result.status));
					compare_field("bytes_received", want.bytes_received, result.bytes_received);
					compare_field("file_crc", want.file_crc, result.file_crc);
					compare_field("chunk_error_count", 32'(want.chunk_error_count),
						32'(result.chunk_error_count));
				end
				if (results_seen == 400 || results_seen == 1300)
					hold_left = LONG_HOLD;
				else
					stall_left = recv_idle_on ? $urandom_range(0, 5) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	logic [7:0] file_data[$];
	int gen_ticks = 0;
	int gen_timeout = 0;
	int items_made = 0;

	function automatic void push_item(input logic [1:0] op, input logic [7:0] b);
		item_t it;
		it.operation = op;
		it.rx_byte = b;
		pending.push_back(it);
		items_made++;
	endfunction

	// occasional tick, kept under the phase timeout
	function automatic void maybe_tick();
		if (gen_ticks < gen_timeout && $urandom_range(0, 9) == 0) begin
			push_item(OP_TICK, 8'($urandom));
			gen_ticks++;
		end
	endfunction

	function automatic void send_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) begin
			maybe_tick();
			push_item(OP_BYTE, w[8*i +: 8]);
		end
		gen_ticks = 0;
	endfunction

	// header, payload and trailer of one chunk; the trailer can be damaged
	function automatic void send_chunk(input int pos, input int len, input bit damage);
		logic [31:0] c;
		c = CRC_INIT;
		send_word(32'(len));
		for (int i = pos; i < pos + len; i++) begin
			maybe_tick();
			push_item(OP_BYTE, file_data[i]);
			c = crc_step(c, file_data[i]);
		end
		gen_ticks = 0;
		if (damage)
			c ^= 32'h1 << $urandom_range(0, 31);
		send_word(~c);
	endfunction

	function automatic logic [31:0] file_crc_of();
		logic [31:0] c;
		c = CRC_INIT;
		foreach (file_data[i])
			c = crc_step(c, file_data[i]);
		return ~c;
	endfunction

	// one upload of file_data; about half of them are broken somewhere
	function automatic void gen_transfer(input logic [31:0] size);
		int mode;
		int pos;
		int len;
		int cut;
		logic [31:0] left;
		mode = $urandom_range(0, 9);
		push_item(OP_START, 8'($urandom));
		gen_ticks = 0;
		pos = 0;
		while (pos < file_data.size()) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 16);
			if (len > file_data.size() - pos)
				len = file_data.size() - pos;
			if (mode >= 5 && ($urandom_range(0, 2) == 0 || pos + len >= file_data.size())) begin
				left = size - 32'(pos);
				case (mode)
					5: send_chunk(pos, len, 1'b1);
					6: send_word(32'h0);
					7: begin
						if (left < CHUNK_MAX_DEF && $urandom_range(0, 1) == 0)
							send_word($urandom_range(left + 1, CHUNK_MAX_DEF));
						else if ($urandom_range(0, 1) == 0)
							send_word(32'hFFFF_FFFF);
						else
							send_word($urandom_range(CHUNK_MAX_DEF + 1, 70000));
					end
					8: begin
						if (gen_timeout <= 40) begin
							repeat (gen_timeout - gen_ticks + 1)
								push_item(OP_TICK, 8'($urandom));
						end else begin
							send_chunk(pos, len, 1'b1);
						end
					end
					default: begin
						// cut off mid-chunk; the next start abandons it
						send_word(32'(len));
						cut = $urandom_range(0, len - 1);
						for (int i = 0; i < cut; i++)
							push_item(OP_BYTE, file_data[pos + i]);
					end
				endcase
				return;
			end
			send_chunk(pos, len, 1'b0);
			pos += len;
		end
		// transfer still open: sometimes a full-size chunk header
		if (size - 32'(pos) >= CHUNK_MAX_DEF && $urandom_range(0, 1) == 0) begin
			send_word(CHUNK_MAX_DEF);
			repeat ($urandom_range(1, 8))
				push_item(OP_BYTE, 8'($urandom));
		end
	endfunction

	// link noise: bytes, ticks and the unused operation
	function automatic void gen_noise();
		item_t it;
		repeat ($urandom_range(0, 3)) begin
			it.operation = 2'($urandom_range(1, 3));
			it.rx_byte = 8'($urandom);
			pending.push_back(it);
		end
	endfunction

	// sender stops until every outstanding result has come back
	task automatic wait_quiet();
		do begin
			@(posedge clk);
			#1;
		end while (pending.size() != 0 || item_valid || expected_results.size() != 0);
	endtask

	task automatic write_regs(input logic [31:0] size, input logic [31:0] crc,
			input logic check, input logic [15:0] ticks);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [31:0] val [4];
		idx = '{CFG_EXP_SIZE, CFG_EXP_CRC, CFG_CRC_CHECK, CFG_TIMEOUT};
		val = '{size, crc, {31'h0, check}, {16'h0, ticks}};
		@(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				CFG_EXP_SIZE:  cfg_expected_size = val[i];
				CFG_EXP_CRC:   cfg_expected_crc = val[i];
				CFG_CRC_CHECK: cfg_crc_check = val[i][0];
				CFG_TIMEOUT:   cfg_timeout = val[i][15:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		#1;
		gen_timeout = int'(ticks);
	endtask

	logic [31:0] run_size;
	logic [31:0] run_crc;
	logic        run_check;
	logic [15:0] run_timeout;
	int          phase_no;
	int          sel;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		#1;

		// idle traffic and an empty upload under the reset settings
		gen_timeout = 0;
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_TICK, 8'h00);
		push_item(OP_UNUSED, 8'hAA);
		push_item(OP_START, 8'h55);
		wait_quiet();

		// one clean two-byte upload with the file crc checked
		file_data = '{8'h00, 8'hFF};
		write_regs(32'd2, file_crc_of(), 1'b1, 16'd1);
		gen_timeout = 0;
		push_item(OP_START, 8'h00);
		send_chunk(0, 2, 1'b0);

		// timeout at a limit of one tick, zero length, oversize length
		push_item(OP_START, 8'h00);
		push_item(OP_TICK, 8'h00);
		push_item(OP_TICK, 8'hFF);
		push_item(OP_START, 8'h00);
		send_word(32'h0);
		push_item(OP_START, 8'h00);
		send_word(CHUNK_MAX_DEF + 1);

		// random uploads, one register setting per round
		items_made = 0;
		phase_no = 0;
		while (items_made < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 19);
			if (phase_no == 0)
				run_size = 32'hFFFF_FFFF;
			else if (phase_no == 1)
				run_size = 32'd1;
			else if (sel < 2)
				run_size = 32'h0;
			else if (sel < 4)
				run_size = $urandom;
			else if (sel < 6)
				run_size = $urandom_range(100, 300);
			else
				run_size = $urandom_range(1, 48);

			file_data.delete();
			repeat ((run_size <= 300) ? int'(run_size) : $urandom_range(0, 40))
				file_data.push_back(8'($urandom));

			sel = $urandom_range(0, 9);
			if (phase_no == 0) begin
				run_timeout = 16'hFFFF;
				run_check = 1'b1;
				run_crc = 32'hFFFF_FFFF;
			end else if (phase_no == 1) begin
				run_timeout = 16'd1;
				run_check = 1'b0;
				run_crc = 32'h0;
			end else begin
				run_timeout = (sel < 4) ? 16'($urandom_range(1, 6)) :
					(sel < 6) ? 16'($urandom_range(7, 65535)) : TIMEOUT_RESET;
				run_check = 1'($urandom);
				run_crc = ($urandom_range(0, 3) != 0) ? file_crc_of() : $urandom;
			end

			wait_quiet();
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			write_regs(run_size, run_crc, run_check, run_timeout);
			repeat ($urandom_range(1, 3)) begin
				gen_transfer(run_size);
				gen_noise();
			end
			phase_no++;
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
